// ===== design/srma_pkg.sv =====
package srma_pkg;

  localparam int WINDOW = 20;
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DATA_W = 8;
  localparam int SUM_W = 14;
  localparam int TICK_W = 20;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] STALE_RESET = TICK_W'(600000);

  // Reciprocal for sum / WINDOW: ceil(2^RECIP_SH / WINDOW), at most one high.
  localparam int RECIP_SH = SUM_W + 2;
  localparam int RECIP_W = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + WINDOW - 1) / WINDOW);

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] reading;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] average;
    logic              restarted;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FILL,
    ST_FINISH
  } state_t;

endpackage

// ===== design/srma_ram.sv =====
module srma_ram #(
  parameter int DEPTH = 20,
  parameter int WIDTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/srma_div.sv =====
module srma_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [srma_pkg::SUM_W-1:0]     dividend,
  output logic                           done,
  output logic [srma_pkg::DATA_W-1:0]    quotient
);

  localparam int PROD_W = srma_pkg::SUM_W + srma_pkg::RECIP_W;

  logic                          busy;
  logic [PROD_W-1:0]             prod;
  logic [srma_pkg::SUM_W-1:0]    held;
  logic [srma_pkg::SUM_W-1:0]    q_est;
  logic [PROD_W-1:0]             q_back;

  // stage 1: multiply by reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(dividend) * PROD_W'(srma_pkg::RECIP);
      held <= dividend;
    end
  end

  // stage 2: estimate is exact or one high
  assign q_est = srma_pkg::SUM_W'(prod >> srma_pkg::RECIP_SH);
  assign q_back = PROD_W'(q_est) * PROD_W'(srma_pkg::WINDOW);

  always_ff @(posedge clk) begin
    if (busy) begin
      if (q_back > PROD_W'(held)) begin
        quotient <= srma_pkg::DATA_W'(q_est - 1'b1);
      end else begin
        quotient <= srma_pkg::DATA_W'(q_est);
      end
    end
  end

endmodule

// ===== design/stale_refill_moving_average.sv =====
// Channel   Direction  Handshake                  Payload
// sample    in         sample_valid/sample_stall  srma_pkg::in_t  (mode, reading)
// result    out        result_valid/result_stall  srma_pkg::out_t (average, restarted)
// config    in         stale_limit_we             stale_limit_data (20 bits)
//
// One transaction at a time. A tick only advances the tick count. A fresh reading steps
// through ring read, update, two-stage reciprocal divide and result load. A first or
// stale reading rewrites the ring through its single write port, one entry at a time.
// Reset (rst, synchronous) clears sum, slot, seen flag and tick count; the ring
// itself is never cleared since a first reading always refills it.
// A result waits in the output register while the next sample is taken; the
// last step of a reading holds until that register is free.
module stale_refill_moving_average (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  srma_pkg::in_t                      sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output srma_pkg::out_t                     result,
  input  logic                               stale_limit_we,
  input  logic [srma_pkg::TICK_W-1:0]        stale_limit_data
);

  localparam int IDX_W = srma_pkg::IDX_W;
  localparam int SUM_W = srma_pkg::SUM_W;
  localparam int DATA_W = srma_pkg::DATA_W;
  localparam int TICK_W = srma_pkg::TICK_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(srma_pkg::WINDOW - 1);

  srma_pkg::state_t state, state_next;

  // control state
  logic [TICK_W-1:0] stale_limit;
  logic [TICK_W-1:0] elapsed, elapsed_next;
  logic              seen, seen_next;
  logic [IDX_W-1:0]  slot, slot_next;
  logic [SUM_W-1:0]  sum, sum_next;
  logic [IDX_W-1:0]  fill_idx, fill_idx_next;
  logic              result_valid_next;

  // per-reading working registers
  logic [DATA_W-1:0] value, value_next;
  logic [DATA_W-1:0] avg, avg_next;
  logic              restart, restart_next;
  srma_pkg::out_t    result_next;

  // ring and divider hookup
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  logic [SUM_W-1:0]  sum_upd;
  logic [SUM_W-1:0]  sum_fill;
  logic [IDX_W-1:0]  slot_inc;
  logic              fresh;

  srma_ram #(
    .DEPTH (srma_pkg::WINDOW),
    .WIDTH (DATA_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // divider takes the updated sum straight from the update step
  srma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_upd),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sample_stall = (state != srma_pkg::ST_IDLE);

  // oldest entry out, new reading in
  assign sum_upd = sum - SUM_W'(ram_rdata) + SUM_W'(value);
  assign sum_fill = SUM_W'(value * srma_pkg::WINDOW);
  assign slot_inc = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign fresh = seen && (elapsed < stale_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= srma_pkg::ST_IDLE;
      stale_limit  <= srma_pkg::STALE_RESET;
      elapsed      <= '0;
      seen         <= 1'b0;
      slot         <= '0;
      sum          <= '0;
      fill_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      if (stale_limit_we) begin
        stale_limit <= stale_limit_data;
      end
      elapsed      <= elapsed_next;
      seen         <= seen_next;
      slot         <= slot_next;
      sum          <= sum_next;
      fill_idx     <= fill_idx_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value   <= value_next;
    avg     <= avg_next;
    restart <= restart_next;
    result  <= result_next;
  end

  always_comb begin
    state_next    = state;
    elapsed_next  = elapsed;
    seen_next     = seen;
    slot_next     = slot;
    sum_next      = sum;
    fill_idx_next = fill_idx;
    value_next    = value;
    avg_next      = avg;
    restart_next  = restart;
    result_next   = result;
    ram_we        = 1'b0;
    ram_waddr     = slot;
    ram_re        = 1'b0;
    div_start     = 1'b0;

    // output register drains independently of the sequencer
    result_valid_next = result_valid && result_stall;

    case (state)
      srma_pkg::ST_IDLE: begin
        if (sample_valid) begin
          if (!sample.mode) begin
            // millisecond tick, saturating
            if (elapsed != srma_pkg::TICK_MAX) begin
              elapsed_next = elapsed + 1'b1;
            end
          end else begin
            value_next   = sample.reading;
            restart_next = !fresh;
            seen_next    = 1'b1;
            elapsed_next = '0;
            if (fresh) begin
              ram_re     = 1'b1;
              state_next = srma_pkg::ST_UPDATE;
            end else begin
              fill_idx_next = '0;
              state_next    = srma_pkg::ST_FILL;
            end
          end
        end
      end

      srma_pkg::ST_UPDATE: begin
        // old entry is on ram_rdata now
        ram_we     = 1'b1;
        sum_next   = sum_upd;
        slot_next  = slot_inc;
        div_start  = 1'b1;
        state_next = srma_pkg::ST_DIVIDE;
      end

      srma_pkg::ST_DIVIDE: begin
        if (div_done) begin
          avg_next   = div_q;
          state_next = srma_pkg::ST_FINISH;
        end
      end

      srma_pkg::ST_FILL: begin
        // stale or first reading: rewrite every entry
        ram_we        = 1'b1;
        ram_waddr     = fill_idx;
        fill_idx_next = fill_idx + 1'b1;
        if (fill_idx == LAST_SLOT) begin
          sum_next   = sum_fill;
          avg_next   = value;
          slot_next  = slot_inc;
          state_next = srma_pkg::ST_FINISH;
        end
      end

      srma_pkg::ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          result_valid_next = 1'b1;
          result_next.average   = avg;
          result_next.restarted = restart;
          state_next = srma_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = srma_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
